>>> hdl/dfr_pkg.sv
`timescale 1ns / 1ps
// dfr_pkg: shared constants, types and index helper for the dedup FIFO.
// No dependencies; imported by dfr_ptr, dedup_fifo_with_removal and the testbench.

package dfr_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ID_W  = 32;
  localparam int MODE_W = 3;
  localparam int OCC_W = 6;

  localparam logic [ID_W-1:0] TOMBSTONE = '1;

  localparam logic [MODE_W-1:0] MODE_PUT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUT_ABSENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GET        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } ptr_cmd_t;

  typedef struct packed {
    logic [AW-1:0] wp;
    logic [AW-1:0] rp;
    logic [CW-1:0] count;
    logic          empty;
    logic          full;
  } ptr_stat_t;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

>>> hdl/dfr_ram.sv
`timescale 1ns / 1ps
// dfr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module dfr_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  logic [W-1:0]                    wr_data,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic [W-1:0]                    rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/dfr_ptr.sv
`timescale 1ns / 1ps
// dfr_ptr: write/read pointers, full flag and occupancy of the circular queue.
// Depends on dfr_pkg.

module dfr_ptr
  import dfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ptr_cmd_t  cmd,
  output ptr_stat_t stat
);

  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic          full;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      wp   <= '0;
      rp   <= '0;
      full <= 1'b0;
    end else if (cmd.push) begin
      wp   <= idx_next(wp);
      full <= (idx_next(wp) == rp);
    end else if (cmd.pop) begin
      rp   <= idx_next(rp);
      full <= 1'b0;
    end
  end

  always_comb begin
    stat.wp    = wp;
    stat.rp    = rp;
    stat.full  = full;
    stat.empty = (wp == rp) && !full;
    if (full) begin
      stat.count = CW'(DEPTH);
    end else if (wp >= rp) begin
      stat.count = CW'(wp - rp);
    end else begin
      stat.count = CW'(DEPTH) - CW'(rp - wp);
    end
  end

endmodule

>>> hdl/dedup_fifo_with_removal.sv
`timescale 1ns / 1ps
// dedup_fifo_with_removal: command sequencer walking the entry RAM one word per cycle.
// Depends on dfr_pkg, dfr_ram, dfr_ptr.
//
//   channel   handshake          payload
//   command   start / busy       mode, pair_id
//   result    done (strobe)      got_id, got_valid, rejected_full, already_present,
//                                occupancy, is_empty, is_full
//
// Put, clear and unused modes: result strobe in the cycle after start.
// Put-if-absent, remove, get: n entries walked (at most DEPTH), a RAM read per cycle,
// each word compared in the cycle after its read; empty queue: strobe next cycle.
// busy is high while walking; a new command may start in the strobe cycle.
// Reset is synchronous; entry RAM is not cleared. Results cannot be stalled.

module dedup_fifo_with_removal
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode,
  input  logic [ID_W-1:0]   pair_id,
  output logic              done,
  output logic [ID_W-1:0]   got_id,
  output logic              got_valid,
  output logic              rejected_full,
  output logic              already_present,
  output logic [OCC_W-1:0]  occupancy,
  output logic              is_empty,
  output logic              is_full
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t            state;
  logic [MODE_W-1:0] op;
  logic [ID_W-1:0]   key;
  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     pend_idx;
  logic [CW-1:0]     issue_left;
  logic [CW-1:0]     pend_left;

  ptr_cmd_t      cmd;
  ptr_stat_t     st;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [ID_W-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [ID_W-1:0] rd_data;

  logic match;
  logic last;
  logic finish;
  logic accept;
  logic walk_mode;

  dfr_ptr u_ptr (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (st)
  );

  dfr_ram #(.W(ID_W), .D(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state == ST_WALK);
  assign accept    = start && !busy;
  assign walk_mode = (mode == MODE_PUT_ABSENT) || (mode == MODE_REMOVE) || (mode == MODE_GET);
  assign match     = (rd_data == key);
  assign last      = (pend_left == CW'(1));
  assign finish    = last || ((op == MODE_PUT_ABSENT) && match) || ((op == MODE_GET) && !match);
  assign rd_addr   = busy ? cur_idx : st.rp;

  assign occupancy = OCC_W'(st.count);
  assign is_empty  = st.empty;
  assign is_full   = st.full;

  always_comb begin
    cmd     = '0;
    wr_en   = 1'b0;
    wr_addr = st.wp;
    wr_data = key;
    if (accept) begin
      wr_data = pair_id;
      unique case (mode)
        MODE_PUT: begin
          if (!st.full) begin
            wr_en    = 1'b1;
            cmd.push = 1'b1;
          end
        end
        MODE_PUT_ABSENT: begin
          if (st.empty) begin
            wr_en    = 1'b1;
            cmd.push = 1'b1;
          end
        end
        MODE_CLEAR: cmd.clr = 1'b1;
        default: ;
      endcase
    end else if (busy) begin
      unique case (op)
        MODE_PUT_ABSENT: begin
          if (!match && last && !st.full) begin
            wr_en    = 1'b1;
            cmd.push = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (match) begin
            wr_en   = 1'b1;
            wr_addr = pend_idx;
            wr_data = TOMBSTONE;
          end
        end
        MODE_GET: cmd.pop = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      got_id          <= '0;
      got_valid       <= 1'b0;
      rejected_full   <= 1'b0;
      already_present <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op         <= mode;
            key        <= (mode == MODE_GET) ? TOMBSTONE : pair_id;
            cur_idx    <= idx_next(st.rp);
            pend_idx   <= st.rp;
            issue_left <= st.count - CW'(1);
            pend_left  <= st.count;
            if (walk_mode && !st.empty) begin
              state <= ST_WALK;
            end else begin
              done            <= 1'b1;
              got_id          <= '0;
              got_valid       <= 1'b0;
              already_present <= 1'b0;
              rejected_full   <= ((mode == MODE_PUT) || (mode == MODE_PUT_ABSENT)) && st.full;
            end
          end
        end
        ST_WALK: begin
          if (issue_left != '0) begin
            cur_idx    <= idx_next(cur_idx);
            issue_left <= issue_left - CW'(1);
          end
          pend_idx  <= idx_next(pend_idx);
          pend_left <= pend_left - CW'(1);
          if (finish) begin
            state           <= ST_IDLE;
            done            <= 1'b1;
            got_valid       <= (op == MODE_GET) && !match;
            got_id          <= ((op == MODE_GET) && !match) ? rd_data : '0;
            already_present <= (op == MODE_PUT_ABSENT) && match;
            rejected_full   <= (op == MODE_PUT_ABSENT) && !match && st.full;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while walking");

  a_got_live: assert property (@(posedge clk) disable iff (rst)
    done && got_valid |-> got_id != TOMBSTONE)
    else $error("get returned a tombstone");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(already_present && rejected_full) && !(got_valid && rejected_full))
    else $error("conflicting result flags");

  a_empty_full: assert property (@(posedge clk) disable iff (rst) !(is_empty && is_full))
    else $error("queue both empty and full");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_CLEAR |=> is_empty && done)
    else $error("clear did not empty the queue");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for dedup_fifo_with_removal, with a clocked driver,
// a clocked monitor and a queue model that predicts each result word.
// Depends on dfr_pkg and the dedup_fifo_with_removal RTL.

module testbench;
  import dfr_pkg::*;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
  } command_t;

  typedef struct {
    logic [ID_W-1:0]  got_id;
    logic             got_valid;
    logic             rejected_full;
    logic             already_present;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
  } status_word_t;

  localparam int POOL_N = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [MODE_W-1:0] mode = MODE_PUT;
  logic [ID_W-1:0]   pair_id = '0;
  logic              busy;
  logic              done;
  logic [ID_W-1:0]   got_id;
  logic              got_valid;
  logic              rejected_full;
  logic              already_present;
  logic [OCC_W-1:0]  occupancy;
  logic              is_empty;
  logic              is_full;

  command_t     pending_cmds[$];
  status_word_t expected_words[$];
  int           errors = 0;

  // queue model
  logic [ID_W-1:0] held_ids[DEPTH];
  int              head_ptr = 0;
  int              tail_ptr = 0;
  bit              at_capacity = 1'b0;

  logic [ID_W-1:0] id_pool[POOL_N];
  bit              no_gaps = 1'b0;
  int              gap_left = 0;
  int              idle_cycles = 0;

  dedup_fifo_with_removal dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .pair_id(pair_id),
    .done(done), .got_id(got_id), .got_valid(got_valid), .rejected_full(rejected_full),
    .already_present(already_present), .occupancy(occupancy), .is_empty(is_empty),
    .is_full(is_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int held_count();
    if (at_capacity) return DEPTH;
    if (tail_ptr >= head_ptr) return tail_ptr - head_ptr;
    return DEPTH - (head_ptr - tail_ptr);
  endfunction

  function automatic bit append_id(logic [ID_W-1:0] id);
    if (at_capacity) return 1'b1;
    held_ids[tail_ptr] = id;
    tail_ptr = (tail_ptr + 1) % DEPTH;
    if (tail_ptr == head_ptr) at_capacity = 1'b1;
    return 1'b0;
  endfunction

  function automatic status_word_t model_command(logic [MODE_W-1:0] cmd,
                                                 logic [ID_W-1:0] id);
    status_word_t w;
    int n;
    int i;
    logic [ID_W-1:0] v;
    w = '{got_id: '0, got_valid: 1'b0, rejected_full: 1'b0, already_present: 1'b0,
          occupancy: '0, is_empty: 1'b0, is_full: 1'b0};
    n = held_count();
    case (cmd)
      MODE_PUT: begin
        w.rejected_full = append_id(id);
      end
      MODE_PUT_ABSENT: begin
        for (i = 0; i < n; i++) begin
          if (held_ids[(head_ptr + i) % DEPTH] == id) w.already_present = 1'b1;
        end
        if (!w.already_present) w.rejected_full = append_id(id);
      end
      MODE_REMOVE: begin
        for (i = 0; i < n; i++) begin
          if (held_ids[(head_ptr + i) % DEPTH] == id) held_ids[(head_ptr + i) % DEPTH] = TOMBSTONE;
        end
      end
      MODE_GET: begin
        while (held_count() > 0 && !w.got_valid) begin
          v = held_ids[head_ptr];
          at_capacity = 1'b0;
          head_ptr = (head_ptr + 1) % DEPTH;
          if (v != TOMBSTONE) begin
            w.got_id = v;
            w.got_valid = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        at_capacity = 1'b0;
      end
      default: begin
      end
    endcase
    w.occupancy = OCC_W'(held_count());
    w.is_empty = (held_count() == 0);
    w.is_full = at_capacity;
    return w;
  endfunction

  function automatic void check_field(string name, logic [ID_W-1:0] exp_v,
                                      logic [ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  // stimulus helpers
  function automatic void add_cmd(logic [MODE_W-1:0] cmd, logic [ID_W-1:0] id);
    command_t c;
    c.mode = cmd;
    c.id = id;
    pending_cmds.push_back(c);
  endfunction

  function automatic void refresh_pool();
    int i;
    for (i = 0; i < POOL_N; i++) begin
      case ($urandom_range(0, 11))
        0: id_pool[i] = '0;
        1: id_pool[i] = TOMBSTONE - 1;
        2: id_pool[i] = TOMBSTONE;
        default: id_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return id_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic void add_random_sequence();
    int n;
    int k;
    int put_pct;
    if ($urandom_range(0, 7) == 0) refresh_pool();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(4, 40);
        put_pct = $urandom_range(0, 100);
        for (k = 0; k < n; k++) begin
          add_cmd(($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_PUT_ABSENT, pick_id());
        end
      end
      3, 4: begin
        n = $urandom_range(2, 36);
        for (k = 0; k < n; k++) add_cmd(MODE_GET, pick_id());
      end
      5, 6: begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) add_cmd(MODE_REMOVE, pick_id());
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) add_cmd(MODE_GET, pick_id());
      end
      7: begin
        add_cmd(MODE_CLEAR, pick_id());
      end
      default: begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          add_cmd(MODE_W'($urandom_range(0, (1 << MODE_W) - 1)),
                  $urandom_range(0, 1) ? $urandom : pick_id());
        end
      end
    endcase
  endfunction

  initial begin
    int directed_n;
    refresh_pool();
    add_cmd(MODE_GET, '0);
    add_cmd(MODE_REMOVE, 32'h0000_0005);
    add_cmd(MODE_PUT_ABSENT, '0);
    add_cmd(MODE_PUT, TOMBSTONE - 1);
    add_cmd(MODE_PUT, TOMBSTONE);
    add_cmd(MODE_PUT_ABSENT, '0);
    add_cmd(MODE_PUT_ABSENT, TOMBSTONE);
    add_cmd(MODE_PUT, 32'hA5A5_A5A5);
    add_cmd(MODE_PUT, 32'h5A5A_5A5A);
    add_cmd(MODE_REMOVE, TOMBSTONE - 1);
    add_cmd(MODE_REMOVE, TOMBSTONE);
    add_cmd(MODE_W'(5), $urandom);
    add_cmd(MODE_W'(6), $urandom);
    add_cmd(MODE_W'(7), $urandom);
    add_cmd(MODE_GET, '0);
    add_cmd(MODE_GET, '0);
    add_cmd(MODE_PUT, 32'h1234_5678);
    add_cmd(MODE_REMOVE, 32'h5A5A_5A5A);
    add_cmd(MODE_REMOVE, 32'h1234_5678);
    add_cmd(MODE_GET, '0);
    add_cmd(MODE_PUT, 32'h0000_0001);
    add_cmd(MODE_PUT, 32'h0000_0002);
    add_cmd(MODE_CLEAR, '0);
    add_cmd(MODE_GET, '0);
    directed_n = pending_cmds.size();
    while (pending_cmds.size() < directed_n + RANDOM_ITEMS) add_random_sequence();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0) @(negedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin : drive_cmds
    command_t nxt;
    status_word_t w;
    bit drive_next;
    int wait_n;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      drive_next = 1'b0;
      if (start && !busy) begin
        w = model_command(mode, pair_id);
        expected_words.push_back(w);
        wait_n = draw_gap();
        if (wait_n == 0 && pending_cmds.size() > 0) begin
          drive_next = 1'b1;
        end else begin
          gap_left = wait_n;
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) gap_left--;
        else if (pending_cmds.size() > 0) drive_next = 1'b1;
      end
      if (drive_next) begin
        nxt = pending_cmds.pop_front();
        mode <= nxt.mode;
        pair_id <= nxt.id;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_words
    status_word_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, actual got_id %h occupancy %0d",
                 $time, got_id, occupancy);
        errors++;
      end else begin
        w = expected_words.pop_front();
        check_field("got_id", w.got_id, got_id);
        check_field("got_valid", ID_W'(w.got_valid), ID_W'(got_valid));
        check_field("rejected_full", ID_W'(w.rejected_full), ID_W'(rejected_full));
        check_field("already_present", ID_W'(w.already_present), ID_W'(already_present));
        check_field("occupancy", ID_W'(w.occupancy), ID_W'(occupancy));
        check_field("is_empty", ID_W'(w.is_empty), ID_W'(is_empty));
        check_field("is_full", ID_W'(w.is_full), ID_W'(is_full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
